@@ rtl/core/avgp_pkg.sv @@
// Shared types, constants and tables for the streaming average-pooling block.
// Used by every module under rtl/core; depends on nothing else.
package avgp_pkg;

  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_KERNEL_DEF  = 8;
  localparam int SAMPLE_BITS_DEF = 16;

  // Plane height limit and the position counter that covers it.
  localparam int MAX_HEIGHT = 1024;
  localparam int ROW_W      = 10;
  localparam int HGT_W      = 11;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // Work queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QCNT_W = 3;

  // Reciprocal table for the stride grid test: floor(x / s) equals
  // (x * recip(s)) >> RECIP_SHIFT for every position the block can hold.
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 21;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_H     = 3'd0,
    REG_KERNEL_W     = 3'd1,
    REG_STRIDE_H     = 3'd2,
    REG_STRIDE_W     = 3'd3,
    REG_IMAGE_WIDTH  = 3'd4,
    REG_IMAGE_HEIGHT = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [3:0]  kernel_h;
    logic [3:0]  kernel_w;
    logic [3:0]  stride_h;
    logic [3:0]  stride_w;
    logic [10:0] image_width;
    logic [10:0] image_height;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_HOLD
  } back_state_t;

  function automatic logic [RECIP_W-1:0] recip(input logic [3:0] s);
    logic [RECIP_W-1:0] m;
    case (s)
      4'd2:    m = 21'd524288;
      4'd3:    m = 21'd349526;
      4'd4:    m = 21'd262144;
      4'd5:    m = 21'd209716;
      4'd6:    m = 21'd174763;
      4'd7:    m = 21'd149797;
      4'd8:    m = 21'd131072;
      4'd9:    m = 21'd116509;
      4'd10:   m = 21'd104858;
      4'd11:   m = 21'd95326;
      4'd12:   m = 21'd87382;
      4'd13:   m = 21'd80660;
      4'd14:   m = 21'd74899;
      4'd15:   m = 21'd69906;
      default: m = 21'd1048576;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/core/avgp_front.sv @@
// Front of the pooling block: position tracking, line memory, window registers
// and the window sum. Depends on avgp_pkg; feeds avgp_queue.
module avgp_front #(
  parameter int MAX_WIDTH   = avgp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_KERNEL  = avgp_pkg::MAX_KERNEL_DEF,
  parameter int SAMPLE_BITS = avgp_pkg::SAMPLE_BITS_DEF,
  parameter int SUM_W       = 22,
  parameter int DIV_W       = 7
) (
  input  logic                              clk,
  input  logic                              rst,
  input  avgp_pkg::cfg_t                    cfg,
  input  logic                              push,
  input  logic signed [SAMPLE_BITS-1:0]     pixel_in,
  output logic                              full,
  input  logic [avgp_pkg::QCNT_W-1:0]       q_level,
  output logic                              job_valid,
  output logic signed [SUM_W-1:0]           job_sum,
  output logic [DIV_W-1:0]                  job_div,
  output logic                              job_last
);

  localparam int KW     = $clog2(MAX_KERNEL + 1);
  localparam int SLOT_W = $clog2(MAX_KERNEL);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int CPOS_W = COL_W + 1;
  localparam int ROW_W  = avgp_pkg::ROW_W;
  localparam int HGT_W  = avgp_pkg::HGT_W;
  localparam int CS_W   = SAMPLE_BITS + $clog2(MAX_KERNEL);
  localparam int RP_W   = ROW_W + avgp_pkg::RECIP_W;
  localparam int CP_W   = COL_W + avgp_pkg::RECIP_W;

  // Effective configuration after range limiting.
  logic [KW-1:0]     kh, kw;
  logic [3:0]        sh, sw;
  logic [CPOS_W-1:0] wcl;
  logic [HGT_W-1:0]  hcl;

  always_comb begin
    kh  = (cfg.kernel_h == '0) ? KW'(1) :
          (int'(cfg.kernel_h) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(cfg.kernel_h);
    kw  = (cfg.kernel_w == '0) ? KW'(1) :
          (int'(cfg.kernel_w) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(cfg.kernel_w);
    sh  = (cfg.stride_h == '0) ? 4'd1 : cfg.stride_h;
    sw  = (cfg.stride_w == '0) ? 4'd1 : cfg.stride_w;
    wcl = (cfg.image_width == '0) ? CPOS_W'(1) :
          (int'(cfg.image_width) > MAX_WIDTH) ? CPOS_W'(MAX_WIDTH) :
          CPOS_W'(cfg.image_width);
    hcl = (cfg.image_height == '0) ? HGT_W'(1) :
          (int'(cfg.image_height) > avgp_pkg::MAX_HEIGHT) ? HGT_W'(avgp_pkg::MAX_HEIGHT) :
          HGT_W'(cfg.image_height);
  end

  // Position of the next sample and its ring slot in the line memory.
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [SLOT_W-1:0] slot;
  logic              acc;
  logic              col_last, row_last, win_open, plane_last;
  logic [ROW_W-1:0]  r0;
  logic [COL_W-1:0]  c0;

  logic v1, v2, v3;

  assign full = (int'(q_level) + int'(v1) + int'(v2) + int'(v3)) >= avgp_pkg::QDEPTH;
  assign acc  = push && !full;

  always_comb begin
    col_last   = (CPOS_W'(col) + CPOS_W'(1)) >= wcl;
    row_last   = (HGT_W'(row) + HGT_W'(1)) >= hcl;
    win_open   = ((HGT_W'(row) + HGT_W'(1)) >= HGT_W'(kh)) &&
                 ((CPOS_W'(col) + CPOS_W'(1)) >= CPOS_W'(kw));
    r0         = ROW_W'(HGT_W'(row) + HGT_W'(1) - HGT_W'(kh));
    c0         = COL_W'(CPOS_W'(col) + CPOS_W'(1) - CPOS_W'(kw));
    plane_last = ((int'(r0) + int'(sh) + int'(kh)) > int'(hcl)) &&
                 ((int'(c0) + int'(sw) + int'(kw)) > int'(wcl));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      slot <= '0;
    end else if (acc) begin
      if (col_last) begin
        col <= '0;
        if (row_last) begin
          row  <= '0;
          slot <= '0;
        end else begin
          row  <= row + ROW_W'(1);
          slot <= (slot == SLOT_W'(MAX_KERNEL - 1)) ? '0 : slot + SLOT_W'(1);
        end
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // Line memory: one bank per ring slot, all banks read at the same column.
  logic signed [SAMPLE_BITS-1:0] line_mem [MAX_KERNEL][MAX_WIDTH];
  logic signed [SAMPLE_BITS-1:0] rd_data  [MAX_KERNEL];

  always_ff @(posedge clk) begin
    if (acc) begin
      line_mem[slot][col] <= pixel_in;
      for (int b = 0; b < MAX_KERNEL; b++) begin
        rd_data[b] <= line_mem[b][col];
      end
    end
  end

  // Stage 1: column assembly, window shift, reciprocal multiply.
  logic signed [SAMPLE_BITS-1:0] p1;
  logic [SLOT_W-1:0]             slot1, slot2;
  logic                          open1, open2, last1, last2, last3, job3;
  logic [ROW_W-1:0]              r0_1, r0_2, rq2;
  logic [COL_W-1:0]              c0_1, c0_2, cq2;
  logic [RP_W-1:0]               rprod;
  logic [CP_W-1:0]               cprod;
  logic signed [SAMPLE_BITS-1:0] win [MAX_KERNEL][MAX_KERNEL];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= acc;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p1    <= pixel_in;
      slot1 <= slot;
      open1 <= win_open;
      last1 <= plane_last;
      r0_1  <= r0;
      c0_1  <= c0;
    end
  end

  always_comb begin
    rprod = RP_W'(r0_1) * RP_W'(avgp_pkg::recip(sh));
    cprod = CP_W'(c0_1) * CP_W'(avgp_pkg::recip(sw));
  end

  // Window column 0 is the newest column; the current sample replaces its bank.
  always_ff @(posedge clk) begin
    if (v1) begin
      for (int b = 0; b < MAX_KERNEL; b++) begin
        win[0][b] <= (SLOT_W'(b) == slot1) ? p1 : rd_data[b];
      end
      for (int j = 1; j < MAX_KERNEL; j++) begin
        win[j] <= win[j-1];
      end
      slot2 <= slot1;
      open2 <= open1;
      last2 <= last1;
      r0_2  <= r0_1;
      c0_2  <= c0_1;
      rq2   <= rprod[avgp_pkg::RECIP_SHIFT +: ROW_W];
      cq2   <= cprod[avgp_pkg::RECIP_SHIFT +: COL_W];
    end
  end

  // Stage 2: masked column sums and the stride grid test.
  logic                   row_inc [MAX_KERNEL];
  logic signed [CS_W-1:0] colsum  [MAX_KERNEL];
  logic signed [CS_W-1:0] colsum3 [MAX_KERNEL];
  logic                   rgrid, cgrid;
  int                     off;

  always_comb begin
    for (int b = 0; b < MAX_KERNEL; b++) begin
      off = (int'(slot2) >= b) ? int'(slot2) - b : int'(slot2) + MAX_KERNEL - b;
      row_inc[b] = off < int'(kh);
    end
    for (int j = 0; j < MAX_KERNEL; j++) begin
      colsum[j] = '0;
      for (int b = 0; b < MAX_KERNEL; b++) begin
        if (row_inc[b]) begin
          colsum[j] = colsum[j] + CS_W'(win[j][b]);
        end
      end
    end
    rgrid = ((ROW_W + 4)'(rq2) * (ROW_W + 4)'(sh)) == (ROW_W + 4)'(r0_2);
    cgrid = ((COL_W + 4)'(cq2) * (COL_W + 4)'(sw)) == (COL_W + 4)'(c0_2);
  end

  always_ff @(posedge clk) begin
    if (v2) begin
      colsum3 <= colsum;
      job3    <= open2 && rgrid && cgrid;
      last3   <= last2;
    end
  end

  // Stage 3: sum over the window columns.
  always_comb begin
    job_sum = '0;
    for (int j = 0; j < MAX_KERNEL; j++) begin
      if (j < int'(kw)) begin
        job_sum = job_sum + SUM_W'(colsum3[j]);
      end
    end
    job_valid = v3 && job3;
    job_div   = DIV_W'(kh) * DIV_W'(kw);
    job_last  = last3;
  end

endmodule

@@ rtl/core/avgp_queue.sv @@
// Short work queue between the pooling front and the divider back end.
// Depends on avgp_pkg for its depth and level width.
module avgp_queue #(
  parameter int WIDTH = 30
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic [WIDTH-1:0]            din,
  input  logic                        pop,
  output logic [WIDTH-1:0]            dout,
  output logic                        nonempty,
  output logic [avgp_pkg::QCNT_W-1:0] level
);

  localparam int DEPTH = avgp_pkg::QDEPTH;
  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + PTR_W'(1);
      end
      if (push && !pop) begin
        level <= level + avgp_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        level <= level - avgp_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= din;
    end
  end

  assign dout     = slots[rptr];
  assign nonempty = level != '0;

`ifndef SYNTH
  // The front reserves room before it accepts a sample, so no overflow.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (int'(level) < DEPTH || pop))
    else $error("work queue pushed while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty)
    else $error("work queue popped while empty");

  a_level_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (level == $past(level) + avgp_pkg::QCNT_W'(1)))
    else $error("work queue level lost a push");
`endif

endmodule

@@ rtl/core/avgp_back.sv @@
// Back end of the pooling block: rounded division of the window sum by the
// window size, one quotient bit per cycle, and the result register.
// Depends on avgp_pkg.
module avgp_back #(
  parameter int SAMPLE_BITS = avgp_pkg::SAMPLE_BITS_DEF,
  parameter int SUM_W       = 22,
  parameter int DIV_W       = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          job_ready,
  input  logic signed [SUM_W-1:0]       job_sum,
  input  logic [DIV_W-1:0]              job_div,
  input  logic                          job_last,
  output logic                          job_take,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [SAMPLE_BITS-1:0] average_out,
  output logic                          plane_done
);

  localparam int NW  = SUM_W + 2;
  localparam int DW  = DIV_W + 1;
  localparam int CNT_W = $clog2(NW);

  avgp_pkg::back_state_t state, state_next;

  logic [NW-1:0]    num, quo;
  logic [DW-1:0]    den, rem;
  logic [DW:0]      remx;
  logic [CNT_W-1:0] cnt;
  logic             neg, last;
  logic             out_valid;
  logic             load, step, emit;
  logic [SUM_W-1:0] mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= avgp_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load       = 1'b0;
    step       = 1'b0;
    emit       = 1'b0;
    unique case (state)
      avgp_pkg::BK_IDLE: begin
        if (job_ready) begin
          load       = 1'b1;
          state_next = avgp_pkg::BK_DIV;
        end
      end
      avgp_pkg::BK_DIV: begin
        step = 1'b1;
        if (cnt == '0) begin
          state_next = avgp_pkg::BK_HOLD;
        end
      end
      avgp_pkg::BK_HOLD: begin
        if (!out_valid || pop) begin
          emit       = 1'b1;
          state_next = avgp_pkg::BK_IDLE;
        end
      end
      default: state_next = avgp_pkg::BK_IDLE;
    endcase
  end

  assign job_take = load;
  assign mag      = job_sum[SUM_W-1] ? SUM_W'(-job_sum) : SUM_W'(job_sum);
  assign remx     = {rem, num[NW-1]};

  // Round half away from zero: (2*|sum| + n) / (2*n), sign applied after.
  always_ff @(posedge clk) begin
    if (load) begin
      neg  <= job_sum[SUM_W-1];
      last <= job_last;
      num  <= (NW'(mag) << 1) + NW'(job_div);
      den  <= DW'(job_div) << 1;
      rem  <= '0;
      quo  <= '0;
      cnt  <= CNT_W'(NW - 1);
    end else if (step) begin
      num <= num << 1;
      cnt <= cnt - CNT_W'(1);
      if (remx >= (DW + 1)'(den)) begin
        rem <= DW'(remx - (DW + 1)'(den));
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= DW'(remx);
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      average_out <= neg ? -quo[SAMPLE_BITS-1:0] : quo[SAMPLE_BITS-1:0];
      plane_done  <= last;
    end
  end

  assign empty = !out_valid;

`ifndef SYNTH
  // The rounded mean of samples never exceeds the sample range.
  a_quo_fits: assert property (@(posedge clk) disable iff (rst)
    (state == avgp_pkg::BK_HOLD) |-> (quo <= (NW'(1) << (SAMPLE_BITS - 1))))
    else $error("average exceeds the sample range");
`endif

endmodule

@@ rtl/core/avg_pool_2d_stream_top.sv @@
// Top level of the streaming 2D average-pooling block: configuration registers
// and the front, queue and back instances. Depends on avgp_pkg and rtl/core.
//
// Samples of one channel plane arrive in raster order, planes one after
// another, and each window whose origin lies on the stride grid yields its
// mean, rounded to nearest with ties away from zero; plane_done marks the last
// mean of a plane. Samples are taken one per cycle as long as the four-entry
// work queue has room for every sample still in the three-stage front pipe.
// A result leaves the front through the stage 1, window and column-sum
// registers after the sample that closes its window, and then passes through
// the bit-serial divider of the back end, which takes one window at a time.
// The line memory holds MAX_KERNEL rows of MAX_WIDTH samples and is not
// cleared by reset.
module avg_pool_2d_stream_top #(
  parameter int MAX_WIDTH   = avgp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_KERNEL  = avgp_pkg::MAX_KERNEL_DEF,
  parameter int SAMPLE_BITS = avgp_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [SAMPLE_BITS-1:0]     pixel_in,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [SAMPLE_BITS-1:0]     average_out,
  output logic                              plane_done,
  input  logic                              cfg_we,
  input  logic [avgp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [avgp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_KERNEL * MAX_KERNEL);
  localparam int DIV_W = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
  localparam int JOB_W = 1 + DIV_W + SUM_W;

  avgp_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kernel_h     <= 4'd2;
      cfg.kernel_w     <= 4'd2;
      cfg.stride_h     <= 4'd2;
      cfg.stride_w     <= 4'd2;
      cfg.image_width  <= 11'd64;
      cfg.image_height <= 11'd64;
    end else if (cfg_we) begin
      unique case (avgp_pkg::cfg_reg_t'(cfg_index))
        avgp_pkg::REG_KERNEL_H:     cfg.kernel_h     <= cfg_data[3:0];
        avgp_pkg::REG_KERNEL_W:     cfg.kernel_w     <= cfg_data[3:0];
        avgp_pkg::REG_STRIDE_H:     cfg.stride_h     <= cfg_data[3:0];
        avgp_pkg::REG_STRIDE_W:     cfg.stride_w     <= cfg_data[3:0];
        avgp_pkg::REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data;
        avgp_pkg::REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                          f_valid, f_last, q_nonempty, q_take;
  logic signed [SUM_W-1:0]       f_sum;
  logic [DIV_W-1:0]              f_div;
  logic [JOB_W-1:0]              q_out;
  logic [avgp_pkg::QCNT_W-1:0]   q_level;

  avgp_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_KERNEL  (MAX_KERNEL),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W),
    .DIV_W       (DIV_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .pixel_in  (pixel_in),
    .full      (full),
    .q_level   (q_level),
    .job_valid (f_valid),
    .job_sum   (f_sum),
    .job_div   (f_div),
    .job_last  (f_last)
  );

  avgp_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (f_valid),
    .din      ({f_last, f_div, f_sum}),
    .pop      (q_take),
    .dout     (q_out),
    .nonempty (q_nonempty),
    .level    (q_level)
  );

  avgp_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W),
    .DIV_W       (DIV_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .job_ready   (q_nonempty),
    .job_sum     (q_out[SUM_W-1:0]),
    .job_div     (q_out[SUM_W +: DIV_W]),
    .job_last    (q_out[JOB_W-1]),
    .job_take    (q_take),
    .empty       (empty),
    .pop         (pop),
    .average_out (average_out),
    .plane_done  (plane_done)
  );

endmodule

@@ tb/avg_pool_2d_stream_top_tb.sv @@
// Self-checking testbench for the streaming 2D average-pooling block.
// Depends on avgp_pkg and avg_pool_2d_stream_top; predicts every window mean itself.
`timescale 1ns / 1ps

module avg_pool_2d_stream_top_tb;

  typedef struct {
    logic signed [15:0] mean;
    logic               last;
  } pool_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic signed [15:0] pixel_in = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [15:0] average_out;
  logic plane_done;
  logic cfg_we = 1'b0;
  logic [avgp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [avgp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  avg_pool_2d_stream_top dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .pixel_in(pixel_in),
    .empty(empty), .pop(pop), .average_out(average_out), .plane_done(plane_done),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Predictor state.
  logic [3:0]  k_h, k_w, s_h, s_w;
  logic [10:0] img_w, img_h;
  logic signed [15:0] line_mem [0:7][0:1023];
  int unsigned row_at, col_at;
  pool_result_t means_due[$];

  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int planes_seen = 0;
  int idle_cycles = 0;
  bit hold_rx = 1'b0;
  bit pressure_req = 1'b0;
  bit pressure_active = 1'b0;
  bit rx_random = 1'b1;

  function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, beats_out);
  endtask

  task automatic predict_pixel(input logic signed [15:0] px);
    int unsigned kh, kw, sh, sw, w, h, r, c, r0, c0;
    longint sum, mag, q, div;
    pool_result_t res;
    kh = clip(k_h, 1, 8);
    kw = clip(k_w, 1, 8);
    sh = clip(s_h, 1, 15);
    sw = clip(s_w, 1, 15);
    w = clip(img_w, 1, 1024);
    h = clip(img_h, 1, 1024);
    r = row_at;
    c = col_at;
    if (c < 1024) line_mem[r % 8][c] = px;
    if (r + 1 >= kh && c + 1 >= kw && c < 1024) begin
      r0 = r + 1 - kh;
      c0 = c + 1 - kw;
      if (r0 % sh == 0 && c0 % sw == 0) begin
        sum = 0;
        for (int i = 0; i < kh; i++)
          for (int j = 0; j < kw; j++)
            sum += line_mem[(r0 + i) % 8][c0 + j];
        div = kh * kw;
        mag = (sum < 0) ? -sum : sum;
        q = (2 * mag + div) / (2 * div);
        res.mean = (sum < 0) ? -q : q;
        res.last = (r0 + sh + kh > h) && (c0 + sw + kw > w);
        means_due.push_back(res);
      end
    end
    if (c + 1 >= w) begin
      col_at = 0;
      row_at = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_at = c + 1;
    end
  endtask

  // Leaves push high after the beat; drain() or a gap in the next call lowers it.
  task automatic send_pixel(input logic signed [15:0] px, input bit gaps = 1'b1);
    int gap;
    gap = gaps ? $urandom_range(0, 13) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) push <= 1'b0;
    repeat (gap) @(negedge clk);
    push <= 1'b1;
    pixel_in <= px;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_pixel(px);
    beats_in++;
    @(negedge clk);
  endtask

  // Waits for every expected mean, then lets the pipe drain.
  task automatic drain();
    push <= 1'b0;
    while (means_due.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(input avgp_pkg::cfg_reg_t idx, input int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[avgp_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      avgp_pkg::REG_KERNEL_H:     k_h = val[3:0];
      avgp_pkg::REG_KERNEL_W:     k_w = val[3:0];
      avgp_pkg::REG_STRIDE_H:     s_h = val[3:0];
      avgp_pkg::REG_STRIDE_W:     s_w = val[3:0];
      avgp_pkg::REG_IMAGE_WIDTH:  img_w = val[10:0];
      avgp_pkg::REG_IMAGE_HEIGHT: img_h = val[10:0];
      default: ;
    endcase
  endtask

  // Position returns to the plane origin only at plane ends, so a new shape is
  // applied only when the stream sits at row 0, column 0.
  task automatic set_shape(input int unsigned kh, kw, sh, sw, w, h);
    drain();
    write_reg(avgp_pkg::REG_KERNEL_H, kh);
    write_reg(avgp_pkg::REG_KERNEL_W, kw);
    write_reg(avgp_pkg::REG_STRIDE_H, sh);
    write_reg(avgp_pkg::REG_STRIDE_W, sw);
    write_reg(avgp_pkg::REG_IMAGE_WIDTH, w);
    write_reg(avgp_pkg::REG_IMAGE_HEIGHT, h);
  endtask

  function automatic logic signed [15:0] rand_pixel();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return $urandom_range(0, 3) - 2;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_plane(input int unsigned w, h);
    for (int i = 0; i < w * h; i++) send_pixel(rand_pixel());
  endtask

  task automatic test_directed();
    // Reset shape 2x2 stride 2 on 64x64 would be long; shrink first.
    set_shape(2, 2, 2, 2, 4, 2);
    // Small exact windows on both signs, and full-scale windows.
    send_pixel(16'sd1); send_pixel(16'sd2); send_pixel(16'sh7fff); send_pixel(16'sh7fff);
    send_pixel(16'sd0); send_pixel(16'sd1); send_pixel(16'sh7fff); send_pixel(16'sh7fff);
    send_pixel(-16'sd1); send_pixel(-16'sd2); send_pixel(16'sh8000); send_pixel(16'sh8000);
    send_pixel(16'sd0); send_pixel(-16'sd1); send_pixel(16'sh8000); send_pixel(16'sh8000);
    // Largest kernel on a plane that fits it exactly.
    set_shape(8, 8, 1, 1, 8, 8);
    send_plane(8, 8);
    // Out-of-range values that clamp: zero kernel/stride/size, oversized kernel.
    set_shape(0, 15, 0, 15, 9, 0);
    send_plane(9, 1);
    set_shape(0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 4; i++) send_pixel(rand_pixel());
    // Plane smaller than kernel gives nothing.
    set_shape(3, 3, 1, 1, 2, 2);
    send_plane(2, 2);
    // Ignored register index.
    push <= 1'b0;
    cfg_we <= 1'b1; cfg_index <= 3'd7; cfg_data <= '1;
    @(negedge clk);
    cfg_we <= 1'b0;
    send_plane(2, 2);
  endtask

  task automatic test_random();
    int unsigned kh, kw, sh, sw, w, h;
    while (beats_in < 430) begin
      kh = $urandom_range(1, 4);
      kw = $urandom_range(1, 4);
      sh = $urandom_range(1, 4);
      sw = $urandom_range(1, 4);
      w = $urandom_range(kw, kw + 8);
      h = $urandom_range(kh, kh + 4);
      if ($urandom_range(0, 15) == 0) begin
        sh = 15; sw = 8;
      end
      set_shape(kh, kw, sh, sw, w, h);
      repeat ($urandom_range(1, 2)) send_plane(w, h);
    end
  endtask

  // One long row: columns far beyond those of the short random planes.
  task automatic test_wide_row();
    set_shape(1, 8, 1, 8, 320, 1);
    for (int i = 0; i < 320; i++) send_pixel(rand_pixel(), 1'b0);
  endtask

  // Result side holds pop low for a long stretch while items keep coming.
  task automatic test_backpressure();
    set_shape(1, 1, 1, 1, 16, 4);
    pressure_req = 1'b1;
    for (int i = 0; i < 64; i++) send_pixel(rand_pixel(), 1'b0);
    pressure_req = 1'b0;
  endtask

  always begin
    @(negedge clk);
    if (pressure_req && !pressure_active) begin
      pressure_active = 1'b1;
      hold_rx = 1'b1;
      repeat (300) @(negedge clk);
      hold_rx = 1'b0;
    end
  end

  // Result side: a random stall before each beat, sometimes none.
  always begin
    int stall;
    @(negedge clk);
    stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
    if (stall != 0 || hold_rx) pop <= 1'b0;
    repeat (stall) @(negedge clk);
    while (hold_rx) @(negedge clk);
    pop <= 1'b1;
    @(posedge clk);
    while (empty) @(posedge clk);
    begin
      pool_result_t want;
      if (means_due.size() == 0) begin
        report("unexpected average_out", average_out, 0);
      end else begin
        want = means_due.pop_front();
        if (average_out !== want.mean) report("average_out", average_out, want.mean);
        if (plane_done !== want.last) report("plane_done", plane_done, want.last);
        if (want.last) planes_seen++;
      end
      beats_out++;
    end
  end

  // Watchdog on cycles with no accepted beat on either side.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || cfg_we || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    k_h = 2; k_w = 2; s_h = 2; s_w = 2; img_w = 64; img_h = 64;
    row_at = 0;
    col_at = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_random();
    test_wide_row();
    drain();
    $display("covered %0d samples in, %0d means out, %0d plane ends", beats_in,
             beats_out, planes_seen);
    if (errors == 0 && means_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
